// ===== src/crfm_pkg.sv =====
// Shared types and constants for the register file and MOVE executor.
// Holds the transaction structs, field codes and the register index mapping.
// No dependencies.
package crfm_pkg;

  localparam int DATA_W      = 32;
  localparam int SR_W        = 16;
  localparam int REG_AW      = 4;
  localparam int REG_CNT     = 16;
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 104;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_MOVE  = 2'd2;

  localparam logic [1:0] MODE_IND = 2'd2;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_WORD = 2'd1;
  localparam logic [1:0] SIZE_LONG = 2'd2;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_MEM2MEM    = 2'd1;
  localparam logic [1:0] ERR_BYTE_MOVEA = 2'd2;

  localparam logic [4:0] SEL_PC    = 5'd0;
  localparam logic [4:0] SEL_SR    = 5'd1;
  localparam logic [4:0] SEL_USP   = 5'd2;
  localparam logic [4:0] SEL_SSP   = 5'd3;
  localparam logic [4:0] SEL_DATA0 = 5'd4;
  localparam logic [4:0] SEL_LAST  = 5'd19;

  localparam logic [SR_W-1:0] SR_RESET     = 16'h2000;
  localparam logic [SR_W-1:0] SR_FLAG_MASK = 16'h000f;
  localparam int              FLAG_N_BIT   = 3;
  localparam int              FLAG_Z_BIT   = 2;

  localparam logic [DATA_W-1:0] MASK_BYTE = 32'h0000_00ff;
  localparam logic [DATA_W-1:0] MASK_WORD = 32'h0000_ffff;
  localparam logic [DATA_W-1:0] MASK_LONG = 32'hffff_ffff;
  localparam logic [DATA_W-1:0] SIGN_BYTE = 32'h0000_0080;
  localparam logic [DATA_W-1:0] SIGN_WORD = 32'h0000_8000;
  localparam logic [DATA_W-1:0] SIGN_LONG = 32'h8000_0000;
  localparam logic [DATA_W-1:0] WORD_EXT  = 32'hffff_0000;

  typedef struct packed {
    logic [1:0]        kind;
    logic [4:0]        reg_select;
    logic [DATA_W-1:0] write_value;
    logic [3:0]        dest_reg;
    logic [1:0]        dest_mode;
    logic [3:0]        source_reg;
    logic [1:0]        source_mode;
    logic [1:0]        op_size;
    logic [DATA_W-1:0] mem_read_data;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic [DATA_W-1:0] mem_addr;
    logic              mem_read_used;
    logic              mem_write_valid;
    logic [DATA_W-1:0] mem_write_data;
    logic [1:0]        mem_write_size;
    logic [1:0]        error_code;
  } result_t;

  // Write-back controls from the execute unit to the register storage
  typedef struct packed {
    logic              ram_we;
    logic [REG_AW-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              pc_we;
    logic              usp_we;
    logic              sr_we;
    logic [SR_W-1:0]   sr_val;
  } wb_t;

  // Map a register select (SSP, D0-D7, A0-A7) onto the register file index
  function automatic logic [REG_AW-1:0] sel_to_idx(input logic [4:0] sel);
    logic [4:0] diff;
    diff = sel - SEL_DATA0;
    return diff[REG_AW-1:0];
  endfunction

endpackage

// ===== src/crfm_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
// Depends on nothing.
module crfm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== src/crfm_exec.sv =====
// Execute unit: decodes one transaction, performs the register read, write or MOVE,
// and produces the result and the write-back controls. Depends on crfm_pkg.
module crfm_exec (
  input  crfm_pkg::item_t                 item,
  input  logic [crfm_pkg::DATA_W-1:0]     sval,
  input  logic [crfm_pkg::DATA_W-1:0]     dval,
  input  logic [crfm_pkg::DATA_W-1:0]     pc,
  input  logic [crfm_pkg::DATA_W-1:0]     usp,
  input  logic [crfm_pkg::SR_W-1:0]       sr,
  output crfm_pkg::result_t               res,
  output crfm_pkg::wb_t                   wb
);

  logic                          sind;
  logic                          dind;
  logic                          movea;
  logic [1:0]                    sz;
  logic [crfm_pkg::DATA_W-1:0]   mask;
  logic [crfm_pkg::DATA_W-1:0]   sign;
  logic [crfm_pkg::DATA_W-1:0]   src;
  logic [crfm_pkg::DATA_W-1:0]   val;
  logic                          sel_in_file;

  always_comb begin
    sind        = (item.source_mode == crfm_pkg::MODE_IND);
    dind        = (item.dest_mode == crfm_pkg::MODE_IND);
    movea       = !dind && item.dest_reg[3];
    sel_in_file = (item.reg_select >= crfm_pkg::SEL_SSP) &&
                  (item.reg_select <= crfm_pkg::SEL_LAST);

    // Size three behaves as long
    if (item.op_size == crfm_pkg::SIZE_BYTE) begin
      sz = crfm_pkg::SIZE_BYTE;
    end else if (item.op_size == crfm_pkg::SIZE_WORD) begin
      sz = crfm_pkg::SIZE_WORD;
    end else begin
      sz = crfm_pkg::SIZE_LONG;
    end

    case (sz)
      crfm_pkg::SIZE_BYTE: begin
        mask = crfm_pkg::MASK_BYTE;
        sign = crfm_pkg::SIGN_BYTE;
      end
      crfm_pkg::SIZE_WORD: begin
        mask = crfm_pkg::MASK_WORD;
        sign = crfm_pkg::SIGN_WORD;
      end
      default: begin
        mask = crfm_pkg::MASK_LONG;
        sign = crfm_pkg::SIGN_LONG;
      end
    endcase

    src = sind ? item.mem_read_data : sval;
    val = src & mask;

    res       = '0;
    wb        = '0;
    wb.sr_val = sr;

    unique case (item.kind)
      crfm_pkg::KIND_READ: begin
        if (item.reg_select == crfm_pkg::SEL_PC) begin
          res.read_value = pc;
        end else if (item.reg_select == crfm_pkg::SEL_SR) begin
          res.read_value = {{(crfm_pkg::DATA_W-crfm_pkg::SR_W){1'b0}}, sr};
        end else if (item.reg_select == crfm_pkg::SEL_USP) begin
          res.read_value = usp;
        end else if (sel_in_file) begin
          res.read_value = sval;
        end
      end
      crfm_pkg::KIND_WRITE: begin
        wb.ram_waddr = crfm_pkg::sel_to_idx(item.reg_select);
        wb.ram_wdata = item.write_value;
        wb.sr_val    = item.write_value[crfm_pkg::SR_W-1:0];
        wb.pc_we     = (item.reg_select == crfm_pkg::SEL_PC);
        wb.sr_we     = (item.reg_select == crfm_pkg::SEL_SR);
        wb.usp_we    = (item.reg_select == crfm_pkg::SEL_USP);
        wb.ram_we    = sel_in_file;
      end
      crfm_pkg::KIND_MOVE: begin
        wb.ram_waddr = item.dest_reg;
        if (sind && dind) begin
          res.error_code = crfm_pkg::ERR_MEM2MEM;
        end else if (movea && sz == crfm_pkg::SIZE_BYTE) begin
          res.error_code = crfm_pkg::ERR_BYTE_MOVEA;
        end else begin
          if (sind) begin
            res.mem_addr      = sval;
            res.mem_read_used = 1'b1;
          end
          if (movea) begin
            // Word MOVEA sign-extends; flags untouched
            wb.ram_we = 1'b1;
            if (sz == crfm_pkg::SIZE_WORD) begin
              wb.ram_wdata = val | (val[15] ? crfm_pkg::WORD_EXT : '0);
            end else begin
              wb.ram_wdata = src;
            end
          end else begin
            wb.sr_we                        = 1'b1;
            wb.sr_val                       = sr & ~crfm_pkg::SR_FLAG_MASK;
            wb.sr_val[crfm_pkg::FLAG_N_BIT] = |(val & sign);
            wb.sr_val[crfm_pkg::FLAG_Z_BIT] = (val == '0);
            if (dind) begin
              res.mem_addr        = dval;
              res.mem_write_valid = 1'b1;
              res.mem_write_data  = val;
              res.mem_write_size  = sz;
            end else begin
              wb.ram_we    = 1'b1;
              wb.ram_wdata = (dval & ~mask) | val;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/cpu_register_file_move.sv =====
// Top level: 68000-style register file with a MOVE executor.
// Depends on crfm_pkg, crfm_ram and crfm_exec.
//
// Input channel (in_*): one transaction per item: a register read, a register
// write or a MOVE.B/W/L. in_tuser carries the kind; in_tdata the remaining fields.
// The memory read value for an (An) source arrives with the item; a memory write
// leaves in the result.
// Result channel (out_*): exactly one result per accepted item, in order.
// D0-D7, A0-A6 and the supervisor stack pointer (also A7) live in a 16-entry
// RAM with one write and two registered read ports; PC, SR and USP are flops.
// Each item takes the RAM's registered read when accepted, then the execute and
// write-back state, which loads the output register and raises out_tvalid; one item
// is in flight at a time, as in_tready stays low until that state completes.
// Reset: PC, USP and the valid bits clear, SR loads 0x2000; a RAM entry whose
// valid bit is clear reads as zero, so no clearing pass is needed.
// Stall: if the receiver holds out_tready low with a result still waiting, the
// next item waits in its execute cycle and write-back is held until the output
// register frees up.
module cpu_register_file_move (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [1:0] kind
  input  logic [1:0]                          in_tuser,
  // [4:0] reg_select, [36:5] write_value, [40:37] dest_reg, [42:41] dest_mode,
  // [46:43] source_reg, [48:47] source_mode, [50:49] op_size,
  // [82:51] mem_read_data, [87:83] zero
  input  logic [crfm_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [31:0] read_value, [63:32] mem_addr, [64] mem_read_used, [65] mem_write_valid,
  // [97:66] mem_write_data, [99:98] mem_write_size, [101:100] error_code,
  // [103:102] zero
  output logic [crfm_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                              state_r;
  logic                              state_nxt;
  crfm_pkg::item_t                   in_item;
  crfm_pkg::item_t                   item_r;
  crfm_pkg::item_t                   cur_item;
  logic [crfm_pkg::REG_CNT-1:0]      vld_r;
  logic [crfm_pkg::DATA_W-1:0]       pc_r;
  logic [crfm_pkg::DATA_W-1:0]       usp_r;
  logic [crfm_pkg::SR_W-1:0]         sr_r;
  logic                              out_valid_r;
  crfm_pkg::result_t                 out_res_r;
  logic [crfm_pkg::REG_AW-1:0]       raddr_a;
  logic [crfm_pkg::REG_AW-1:0]       raddr_b;
  logic [crfm_pkg::REG_AW-1:0]       ex_addr_a;
  logic [crfm_pkg::DATA_W-1:0]       rdata_a;
  logic [crfm_pkg::DATA_W-1:0]       rdata_b;
  logic [crfm_pkg::DATA_W-1:0]       sval;
  logic [crfm_pkg::DATA_W-1:0]       dval;
  crfm_pkg::result_t                 res;
  crfm_pkg::wb_t                     wb;
  logic                              accept;
  logic                              done;

  assign in_item.kind          = in_tuser;
  assign in_item.reg_select    = in_tdata[4:0];
  assign in_item.write_value   = in_tdata[36:5];
  assign in_item.dest_reg      = in_tdata[40:37];
  assign in_item.dest_mode     = in_tdata[42:41];
  assign in_item.source_reg    = in_tdata[46:43];
  assign in_item.source_mode   = in_tdata[48:47];
  assign in_item.op_size       = in_tdata[50:49];
  assign in_item.mem_read_data = in_tdata[82:51];

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign done      = (state_r == ST_EXEC) && (!out_valid_r || out_tready);

  // Address the RAM from the incoming item while idle, from the held item after
  assign cur_item  = (state_r == ST_IDLE) ? in_item : item_r;
  assign raddr_a   = (cur_item.kind == crfm_pkg::KIND_MOVE) ? cur_item.source_reg
                                                            : crfm_pkg::sel_to_idx(cur_item.reg_select);
  assign raddr_b   = cur_item.dest_reg;
  assign ex_addr_a = (item_r.kind == crfm_pkg::KIND_MOVE) ? item_r.source_reg
                                                          : crfm_pkg::sel_to_idx(item_r.reg_select);

  // Entries never written since reset read as zero
  assign sval = vld_r[ex_addr_a] ? rdata_a : '0;
  assign dval = vld_r[item_r.dest_reg] ? rdata_b : '0;

  crfm_ram #(
    .WIDTH (crfm_pkg::DATA_W),
    .DEPTH (crfm_pkg::REG_CNT)
  ) u_regs (
    .clk     (clk),
    .we      (done && wb.ram_we),
    .waddr   (wb.ram_waddr),
    .wdata   (wb.ram_wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  crfm_exec u_exec (
    .item (item_r),
    .sval (sval),
    .dval (dval),
    .pc   (pc_r),
    .usp  (usp_r),
    .sr   (sr_r),
    .res  (res),
    .wb   (wb)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= '0;
      pc_r        <= '0;
      usp_r       <= '0;
      sr_r        <= crfm_pkg::SR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (done) begin
        out_valid_r <= 1'b1;
        if (wb.ram_we) begin
          vld_r[wb.ram_waddr] <= 1'b1;
        end
        if (wb.pc_we) begin
          pc_r <= wb.ram_wdata;
        end
        if (wb.usp_we) begin
          usp_r <= wb.ram_wdata;
        end
        if (wb.sr_we) begin
          sr_r <= wb.sr_val;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: hold item and result
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    if (done) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00,
                       out_res_r.error_code,
                       out_res_r.mem_write_size,
                       out_res_r.mem_write_data,
                       out_res_r.mem_write_valid,
                       out_res_r.mem_read_used,
                       out_res_r.mem_addr,
                       out_res_r.read_value};

  // An accepted item always moves into its execute cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_EXEC))
    else $error("accepted transaction did not enter execute");

  // Completion must never overwrite a result still waiting at the output
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");

  // A faulted move leaves state and memory untouched
  a_err_no_effect: assert property (@(posedge clk) disable iff (!rst_n)
    (done && res.error_code != crfm_pkg::ERR_NONE) |->
      (!wb.ram_we && !wb.sr_we && !res.mem_read_used && !res.mem_write_valid))
    else $error("faulted move has side effects");

endmodule

// ===== verif/cpu_register_file_move_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for cpu_register_file_move: register reads, writes and
// MOVE transactions checked against an in-bench model of the register file.
// Depends on crfm_pkg and the cpu_register_file_move RTL.
module cpu_register_file_move_tb;

  localparam logic [1:0] KIND_NONE   = 2'd3;
  localparam logic [1:0] MODE_DREG   = 2'd0;
  localparam logic [1:0] MODE_AREG   = 2'd1;
  localparam logic [1:0] MODE_RSVD   = 2'd3;
  localparam logic [1:0] SIZE_RSVD   = 2'd3;
  localparam logic [3:0] REG_D0      = 4'd0;
  localparam logic [3:0] REG_A0      = 4'd8;
  localparam logic [4:0] SEL_ADDR0   = 5'd12;
  localparam logic [4:0] SEL_NONE_HI = 5'd31;
  localparam int         LONG_HOLD   = 300;
  localparam int         STALL_LIMIT = 5000;
  localparam int         PHASE_ITEMS = 300;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [1:0]                       in_tuser   = '0;
  logic [crfm_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [crfm_pkg::OUT_TDATA_W-1:0] out_tdata;

  typedef struct {
    crfm_pkg::item_t   it;
    bit                typed;
    crfm_pkg::result_t want;
  } stim_row_t;

  // Model copy of the architectural state
  logic [crfm_pkg::DATA_W-1:0] d_regs [8];
  logic [crfm_pkg::DATA_W-1:0] a_regs [7];
  logic [crfm_pkg::DATA_W-1:0] usp_q, ssp_q, pc_q;
  logic [crfm_pkg::SR_W-1:0]   sr_q;

  crfm_pkg::result_t pending_results [$];
  stim_row_t         stim_table [$];
  int                err_count      = 0;
  int                src_idle_pct   = 0;
  int                sink_stall_pct = 0;
  int                hold_asked     = 0;
  int                hold_done      = 0;
  int                hold_left      = 0;
  int                quiet_cycles   = 0;

  always #5 clk = ~clk;

  cpu_register_file_move dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // D0-D7 are 0-7, A0-A6 are 8-14, and 15 is A7, which is the supervisor pointer
  function automatic logic [crfm_pkg::DATA_W-1:0] reg_rd(input logic [3:0] r);
    if (!r[3]) return d_regs[r[2:0]];
    if (r[2:0] != 3'd7) return a_regs[r[2:0]];
    return ssp_q;
  endfunction

  task automatic reg_wr(input logic [3:0] r, input logic [crfm_pkg::DATA_W-1:0] v);
    if (!r[3]) d_regs[r[2:0]] = v;
    else if (r[2:0] != 3'd7) a_regs[r[2:0]] = v;
    else ssp_q = v;
  endtask

  function automatic logic [crfm_pkg::DATA_W-1:0] sel_rd(input logic [4:0] sel);
    logic [4:0] off;
    off = sel - crfm_pkg::SEL_DATA0;
    case (sel)
      crfm_pkg::SEL_PC:  return pc_q;
      crfm_pkg::SEL_SR:  return {16'h0, sr_q};
      crfm_pkg::SEL_USP: return usp_q;
      crfm_pkg::SEL_SSP: return ssp_q;
      default: return (sel <= crfm_pkg::SEL_LAST) ? reg_rd(off[3:0]) : '0;
    endcase
  endfunction

  task automatic sel_wr(input logic [4:0] sel, input logic [crfm_pkg::DATA_W-1:0] v);
    logic [4:0] off;
    off = sel - crfm_pkg::SEL_DATA0;
    case (sel)
      crfm_pkg::SEL_PC:  pc_q = v;
      crfm_pkg::SEL_SR:  sr_q = v[crfm_pkg::SR_W-1:0];
      crfm_pkg::SEL_USP: usp_q = v;
      crfm_pkg::SEL_SSP: ssp_q = v;
      default: if (sel <= crfm_pkg::SEL_LAST) reg_wr(off[3:0], v);
    endcase
  endtask

  // Execute one instruction on the model state and return the transaction it produces
  task automatic run_instruction(input crfm_pkg::item_t it, output crfm_pkg::result_t r);
    logic [1:0]                  sz;
    logic [crfm_pkg::DATA_W-1:0] mask, sign, src, val;
    logic                        sind, dind;
    r    = '0;
    src  = '0;
    sind = (it.source_mode == crfm_pkg::MODE_IND);
    dind = (it.dest_mode == crfm_pkg::MODE_IND);
    sz   = (it.op_size == SIZE_RSVD) ? crfm_pkg::SIZE_LONG : it.op_size;
    mask = (sz == crfm_pkg::SIZE_BYTE) ? crfm_pkg::MASK_BYTE :
           (sz == crfm_pkg::SIZE_WORD) ? crfm_pkg::MASK_WORD : crfm_pkg::MASK_LONG;
    sign = (sz == crfm_pkg::SIZE_BYTE) ? crfm_pkg::SIGN_BYTE :
           (sz == crfm_pkg::SIZE_WORD) ? crfm_pkg::SIGN_WORD : crfm_pkg::SIGN_LONG;
    case (it.kind)
      crfm_pkg::KIND_READ:  r.read_value = sel_rd(it.reg_select);
      crfm_pkg::KIND_WRITE: sel_wr(it.reg_select, it.write_value);
      crfm_pkg::KIND_MOVE: begin
        if (sind) begin
          r.mem_addr      = reg_rd(it.source_reg);
          r.mem_read_used = 1'b1;
          src             = it.mem_read_data;
        end else begin
          src = reg_rd(it.source_reg);
        end
        if (sind && dind) begin
          r            = '0;
          r.error_code = crfm_pkg::ERR_MEM2MEM;
        end else if (!dind && it.dest_reg[3]) begin
          // MOVEA: whole register, word sign-extended, flags untouched
          if (sz == crfm_pkg::SIZE_BYTE) begin
            r            = '0;
            r.error_code = crfm_pkg::ERR_BYTE_MOVEA;
          end else begin
            if (sz == crfm_pkg::SIZE_WORD) src = {{16{src[15]}}, src[15:0]};
            reg_wr(it.dest_reg, src);
          end
        end else begin
          val                        = src & mask;
          sr_q                       = sr_q & ~crfm_pkg::SR_FLAG_MASK;
          sr_q[crfm_pkg::FLAG_N_BIT] = |(val & sign);
          sr_q[crfm_pkg::FLAG_Z_BIT] = (val == '0);
          if (dind) begin
            r.mem_addr        = reg_rd(it.dest_reg);
            r.mem_write_valid = 1'b1;
            r.mem_write_data  = val;
            r.mem_write_size  = sz;
          end else begin
            reg_wr(it.dest_reg, (reg_rd(it.dest_reg) & ~mask) | val);
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic crfm_pkg::item_t reg_op(input logic [1:0] k, input logic [4:0] sel,
                                             input logic [crfm_pkg::DATA_W-1:0] wv);
    crfm_pkg::item_t it;
    it             = '0;
    it.kind        = k;
    it.reg_select  = sel;
    it.write_value = wv;
    return it;
  endfunction

  function automatic crfm_pkg::item_t move_op(input logic [3:0] dr, input logic [1:0] dm,
                                              input logic [3:0] sr, input logic [1:0] sm,
                                              input logic [1:0] sz,
                                              input logic [crfm_pkg::DATA_W-1:0] md);
    crfm_pkg::item_t it;
    it               = '0;
    it.kind          = crfm_pkg::KIND_MOVE;
    it.dest_reg      = dr;
    it.dest_mode     = dm;
    it.source_reg    = sr;
    it.source_mode   = sm;
    it.op_size       = sz;
    it.mem_read_data = md;
    return it;
  endfunction

  function automatic crfm_pkg::result_t known_result(input logic [crfm_pkg::DATA_W-1:0] rv,
                                                     input logic [1:0] err);
    crfm_pkg::result_t r;
    r            = '0;
    r.read_value = rv;
    r.error_code = err;
    return r;
  endfunction

  task automatic add_row(input crfm_pkg::item_t it, input bit typed,
                         input crfm_pkg::result_t want);
    stim_table.push_back('{it, typed, want});
  endtask

  function automatic logic [crfm_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return $urandom & 32'hffff_ff00;
      3:       return $urandom & 32'hffff_0000;
      4:       return $urandom | 32'h8080_8080;
      5:       return $urandom & 32'h7f7f_7f7f;
      default: return $urandom;
    endcase
  endfunction

  function automatic crfm_pkg::item_t rand_instr();
    crfm_pkg::item_t it;
    int              roll;
    roll             = $urandom_range(0, 99);
    it.kind          = (roll < 45) ? crfm_pkg::KIND_MOVE : (roll < 70) ? crfm_pkg::KIND_WRITE :
                       (roll < 96) ? crfm_pkg::KIND_READ : KIND_NONE;
    it.reg_select    = ($urandom_range(0, 9) == 0) ?
                       5'($urandom_range(crfm_pkg::SEL_LAST + 1, SEL_NONE_HI)) :
                       5'($urandom_range(crfm_pkg::SEL_PC, crfm_pkg::SEL_LAST));
    it.write_value   = pick_value();
    it.dest_reg      = 4'($urandom);
    it.dest_mode     = 2'($urandom);
    it.source_reg    = 4'($urandom);
    it.source_mode   = 2'($urandom);
    it.op_size       = 2'($urandom);
    it.mem_read_data = pick_value();
    return it;
  endfunction

  task automatic send_item(input crfm_pkg::item_t it, input bit typed,
                           input crfm_pkg::result_t want);
    crfm_pkg::result_t pred;
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.kind;
    in_tdata  <= {5'b0, it.mem_read_data, it.op_size, it.source_mode, it.source_reg,
                  it.dest_mode, it.dest_reg, it.write_value, it.reg_select};
    do @(posedge clk); while (!in_tready);
    run_instruction(it, pred);
    pending_results.push_back(typed ? want : pred);
  endtask

  function automatic void compare_field(input string name,
                                        input logic [crfm_pkg::DATA_W-1:0] e,
                                        input logic [crfm_pkg::DATA_W-1:0] a);
    if (e !== a) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
      err_count++;
    end
  endfunction

  // Receiver: random stalls, plus one long hold-off counted here
  always @(negedge clk) begin
    if (hold_asked != hold_done) begin
      hold_done++;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    crfm_pkg::result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.read_value      = out_tdata[31:0];
      got.mem_addr        = out_tdata[63:32];
      got.mem_read_used   = out_tdata[64];
      got.mem_write_valid = out_tdata[65];
      got.mem_write_data  = out_tdata[97:66];
      got.mem_write_size  = out_tdata[99:98];
      got.error_code      = out_tdata[101:100];
      if (pending_results.size() == 0) begin
        $error("result 0x%0h arrived with nothing expected", out_tdata);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("read_value", want.read_value, got.read_value);
        compare_field("mem_addr", want.mem_addr, got.mem_addr);
        compare_field("mem_read_used", 32'(want.mem_read_used), 32'(got.mem_read_used));
        compare_field("mem_write_valid", 32'(want.mem_write_valid),
                      32'(got.mem_write_valid));
        compare_field("mem_write_data", want.mem_write_data, got.mem_write_data);
        compare_field("mem_write_size", 32'(want.mem_write_size), 32'(got.mem_write_size));
        compare_field("error_code", 32'(want.error_code), 32'(got.error_code));
      end
    end
  end

  // Watchdog: drop out if no transaction moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[cpu_register_file_move] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int ph, n;
    foreach (d_regs[i]) d_regs[i] = '0;
    foreach (a_regs[i]) a_regs[i] = '0;
    usp_q = '0;
    ssp_q = '0;
    pc_q  = '0;
    sr_q  = crfm_pkg::SR_RESET;

    add_row(reg_op(crfm_pkg::KIND_READ, crfm_pkg::SEL_SR, '0), 1'b1,
            known_result(32'h2000, crfm_pkg::ERR_NONE));
    add_row(reg_op(crfm_pkg::KIND_READ, crfm_pkg::SEL_PC, '0), 1'b1,
            known_result('0, crfm_pkg::ERR_NONE));
    add_row(reg_op(crfm_pkg::KIND_READ, SEL_NONE_HI, '1), 1'b1,
            known_result('0, crfm_pkg::ERR_NONE));
    add_row(reg_op(crfm_pkg::KIND_WRITE, crfm_pkg::SEL_PC, '1), 1'b1,
            known_result('0, crfm_pkg::ERR_NONE));
    add_row(reg_op(crfm_pkg::KIND_READ, crfm_pkg::SEL_PC, '0), 1'b1,
            known_result('1, crfm_pkg::ERR_NONE));
    add_row(reg_op(crfm_pkg::KIND_WRITE, crfm_pkg::SEL_SR, '1), 1'b1,
            known_result('0, crfm_pkg::ERR_NONE));
    add_row(reg_op(crfm_pkg::KIND_READ, crfm_pkg::SEL_SR, '0), 1'b1,
            known_result(32'h0000_ffff, crfm_pkg::ERR_NONE));
    add_row(reg_op(crfm_pkg::KIND_WRITE, crfm_pkg::SEL_DATA0, 32'h1234_8000), 1'b0, '0);
    add_row(reg_op(crfm_pkg::KIND_WRITE, crfm_pkg::SEL_LAST, 32'h0000_1000), 1'b0, '0);
    add_row(reg_op(crfm_pkg::KIND_READ, crfm_pkg::SEL_SSP, '0), 1'b1,
            known_result(32'h0000_1000, crfm_pkg::ERR_NONE));
    add_row(reg_op(crfm_pkg::KIND_WRITE, crfm_pkg::SEL_USP, 32'ha5a5_a5a5), 1'b0, '0);
    add_row(reg_op(crfm_pkg::KIND_WRITE, SEL_ADDR0, 32'h0000_0080), 1'b0, '0);
    add_row(reg_op(crfm_pkg::KIND_WRITE, SEL_NONE_HI, 32'hdead_beef), 1'b0, '0);
    add_row(reg_op(crfm_pkg::KIND_READ, crfm_pkg::SEL_USP, '0), 1'b0, '0);
    // byte of D0 is zero, byte of A0 is negative
    add_row(move_op(REG_D0 + 1, MODE_DREG, REG_D0, MODE_DREG, crfm_pkg::SIZE_BYTE, '0),
            1'b0, '0);
    add_row(move_op(REG_D0 + 2, MODE_DREG, REG_A0, MODE_AREG, crfm_pkg::SIZE_BYTE, '0),
            1'b0, '0);
    add_row(move_op(REG_D0 + 3, MODE_DREG, REG_A0 + 7, crfm_pkg::MODE_IND,
                    crfm_pkg::SIZE_LONG, '1), 1'b0, '0);
    add_row(move_op(REG_D0 + 4, crfm_pkg::MODE_IND, REG_A0, crfm_pkg::MODE_IND,
                    crfm_pkg::SIZE_WORD, '1), 1'b1,
            known_result('0, crfm_pkg::ERR_MEM2MEM));
    add_row(move_op(REG_A0 + 1, MODE_AREG, REG_D0, MODE_DREG, crfm_pkg::SIZE_BYTE, '0), 1'b1,
            known_result('0, crfm_pkg::ERR_BYTE_MOVEA));
    add_row(move_op(REG_A0 + 2, MODE_AREG, REG_D0, MODE_DREG, crfm_pkg::SIZE_WORD, '0),
            1'b0, '0);
    add_row(move_op(REG_A0 + 7, crfm_pkg::MODE_IND, REG_D0, MODE_DREG,
                    crfm_pkg::SIZE_LONG, '0), 1'b0, '0);
    add_row(move_op(REG_D0 + 5, MODE_RSVD, REG_D0 + 3, MODE_RSVD, SIZE_RSVD, '0), 1'b0, '0);
    add_row(move_op(REG_A0 + 7, MODE_DREG, REG_A0 + 2, crfm_pkg::MODE_IND,
                    crfm_pkg::SIZE_LONG, 32'h8000_0000), 1'b0, '0);
    add_row(crfm_pkg::item_t'('1), 1'b1, known_result('0, crfm_pkg::ERR_NONE));
    add_row(reg_op(crfm_pkg::KIND_READ, crfm_pkg::SEL_SR, '0), 1'b0, '0);

    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i]) send_item(stim_table[i].it, stim_table[i].typed, stim_table[i].want);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 49; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 49; end
        default: begin src_idle_pct = 26; sink_stall_pct = 26; end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == 100) hold_asked++;
        if (ph == 2 && n == 150) begin
          // pause the sender until the block has drained
          @(negedge clk) in_tvalid <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
        end
        send_item(rand_instr(), 1'b0, '0);
      end
    end
    @(negedge clk) in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("[cpu_register_file_move] OK");
    end else begin
      $display("[cpu_register_file_move] ERROR");
    end
    $finish;
  end

endmodule
